// ===== rtl/ppmq_pkg.sv =====
`default_nettype none
package ppmq_pkg;

	// buffer geometry
	localparam int BUFFER_DEPTH = 256;
	localparam int MESSAGE_MAX  = 32;

	localparam int IDX_W  = $clog2(BUFFER_DEPTH);   // index inside one buffer
	localparam int CNT_W  = IDX_W + 1;              // fill / cursor, holds BUFFER_DEPTH
	localparam int ADDR_W = IDX_W + 1;              // {side, index}
	localparam int MEM_DEPTH = 2 * BUFFER_DEPTH;
	localparam int MSG_W  = $clog2(MESSAGE_MAX);

	localparam int DATA_W  = 32;
	localparam int ENTRY_W = 2 * DATA_W;            // {tag, value}
	localparam int KIND_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] FILL_FULL    = CNT_W'(BUFFER_DEPTH);
	localparam logic [CNT_W-1:0] FILL_BEGIN   = CNT_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] FILL_ADD_MAX = CNT_W'(BUFFER_DEPTH - 4);
	localparam logic [MSG_W-1:0] MSG_LIMIT    = MSG_W'(MESSAGE_MAX - 1);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SWAP  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FETCH = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ID_TAG  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_TAG = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/ppmq_ram.sv =====
`default_nettype none
module ppmq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ping_pong_tag_message_queue_core.sv =====
// A begin, add, end or swap item gives its one result in the output register in the cycle
// after accept. Fetch: the memory read is registered, then one entry is loaded per cycle
// unless out_stall holds it, and an appended end tag follows. Throughput is one write or
// swap item per cycle unless stalled; a fetch stalls new items until its last result is loaded.
// Reset (arst_n low, asynchronous) clears fill counts, side, cursors, tags and the sequencer;
// the entry memory is not cleared and needs no clearing pass.
`default_nettype none
module ping_pong_tag_message_queue_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [ppmq_pkg::KIND_W-1:0]    kind,
	input  wire logic [ppmq_pkg::DATA_W-1:0]    entry_tag_in,
	input  wire logic [ppmq_pkg::DATA_W-1:0]    entry_value_in,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic                           accepted,
	output      logic                           pending,
	output      logic                           entry_valid,
	output      logic [ppmq_pkg::DATA_W-1:0]    entry_tag_out,
	output      logic [ppmq_pkg::DATA_W-1:0]    entry_value_out,
	output      logic                           last,
	input  wire logic                           cfg_we,
	input  wire logic [ppmq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ppmq_pkg::DATA_W-1:0]    cfg_data
);
	import ppmq_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EMIT   = 2'd1;
	localparam logic [1:0] ST_APPEND = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  fill_a_q, fill_a_d, fill_b_q, fill_b_d;
	logic              ws_q, ws_d;
	logic [CNT_W-1:0]  rc_q, rc_d, de_q, de_d;
	logic [MSG_W-1:0]  n_q, n_d;
	logic [DATA_W-1:0] id_tag_q, end_tag_q;

	logic              out_valid_q;
	logic              o_acc_q, o_pend_q, o_ev_q, o_last_q;
	logic [DATA_W-1:0] o_tag_q, o_val_q;

	logic              ld, o_acc, o_pend, o_ev, o_last;
	logic [DATA_W-1:0] o_tag, o_val;

	logic              out_free, in_acc;
	logic [CNT_W-1:0]  wfill, rc_inc;
	logic [MSG_W-1:0]  n_inc;
	logic              wr_ok, ram_we, ram_re;
	logic [DATA_W-1:0] wr_tag, wr_val;
	logic [IDX_W-1:0]  rd_idx;
	logic [ENTRY_W-1:0] rdata;
	logic [CNT_W-1:0]  wr_limit;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign wfill    = ws_q ? fill_b_q : fill_a_q;
	assign rc_inc   = rc_q + 1'b1;
	assign n_inc    = n_q + 1'b1;
	assign wr_limit = (wr_tag == end_tag_q) ? FILL_FULL : FILL_ADD_MAX;

	always_comb begin
		state_d  = state_q;
		fill_a_d = fill_a_q;
		fill_b_d = fill_b_q;
		ws_d     = ws_q;
		rc_d     = rc_q;
		de_d     = de_q;
		n_d      = n_q;
		ld       = 1'b0;
		o_acc    = 1'b0;
		o_pend   = 1'b0;
		o_ev     = 1'b0;
		o_tag    = '0;
		o_val    = '0;
		o_last   = 1'b1;
		wr_tag   = entry_tag_in;
		wr_val   = entry_value_in;
		wr_ok    = 1'b0;
		ram_re   = 1'b0;
		rd_idx   = rc_q[IDX_W-1:0];
		case (kind)
			KIND_BEGIN: wr_tag = id_tag_q;
			KIND_END: begin
				wr_tag = end_tag_q;
				wr_val = '0;
			end
			default: ;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_BEGIN: begin
							wr_ok = (wfill < FILL_BEGIN) && (wfill < wr_limit);
							ld    = 1'b1;
							o_acc = wr_ok;
						end
						KIND_ADD, KIND_END: begin
							wr_ok = wfill < wr_limit;
							ld    = 1'b1;
							o_acc = wr_ok;
						end
						KIND_SWAP: begin
							ld = 1'b1;
							if (rc_q >= de_q) begin
								ws_d   = !ws_q;
								de_d   = wfill;
								rc_d   = '0;
								o_pend = wfill != '0;
								if (ws_q) begin
									fill_a_d = '0;
								end else begin
									fill_b_d = '0;
								end
							end else begin
								o_pend = 1'b1;
							end
						end
						KIND_FETCH: begin
							if (rc_q >= de_q) begin
								ld = 1'b1;  // empty drain: one invalid result
							end else begin
								ram_re  = 1'b1;
								n_d     = '0;
								state_d = ST_EMIT;
							end
						end
						default: ;
					endcase
					if (wr_ok) begin
						if (ws_q) begin
							fill_b_d = fill_b_q + 1'b1;
						end else begin
							fill_a_d = fill_a_q + 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld    = 1'b1;
					o_ev  = 1'b1;
					o_tag = rdata[ENTRY_W-1:DATA_W];
					o_val = rdata[DATA_W-1:0];
					rc_d  = rc_inc;
					n_d   = n_inc;
					if (o_tag == end_tag_q) begin
						state_d = ST_IDLE;
					end else if ((rc_inc < de_q) && (n_inc < MSG_LIMIT)) begin
						o_last = 1'b0;
						ram_re = 1'b1;
						rd_idx = rc_inc[IDX_W-1:0];
					end else begin
						o_last  = 1'b0;
						state_d = ST_APPEND;
					end
				end
			end
			ST_APPEND: begin
				if (out_free) begin
					ld      = 1'b1;
					o_ev    = 1'b1;
					o_tag   = end_tag_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign ram_we = wr_ok;

	ppmq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr({ws_q, wfill[IDX_W-1:0]}),
		.wdata({wr_tag, wr_val}),
		.re   (ram_re),
		.raddr({!ws_q, rd_idx}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_a_q    <= '0;
			fill_b_q    <= '0;
			ws_q        <= 1'b0;
			rc_q        <= '0;
			de_q        <= '0;
			n_q         <= '0;
			id_tag_q    <= '0;
			end_tag_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_a_q <= fill_a_d;
			fill_b_q <= fill_b_d;
			ws_q     <= ws_d;
			rc_q     <= rc_d;
			de_q     <= de_d;
			n_q      <= n_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ID_TAG:  id_tag_q  <= cfg_data;
					CFG_END_TAG: end_tag_q <= cfg_data;
					default: ;
				endcase
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			o_acc_q  <= o_acc;
			o_pend_q <= o_pend;
			o_ev_q   <= o_ev;
			o_tag_q  <= o_tag;
			o_val_q  <= o_val;
			o_last_q <= o_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = o_acc_q;
	assign pending         = o_pend_q;
	assign entry_valid     = o_ev_q;
	assign entry_tag_out   = o_tag_q;
	assign entry_value_out = o_val_q;
	assign last            = o_last_q;

endmodule
`default_nettype wire
